[hw/rtl/sqrot_pkg.sv]
// Shared constants, register map and helpers of the square image quarter rotator.
// Used by the top level; depends on nothing else.
package sqrot_pkg;

    localparam int MAX_SIDE     = 64;
    localparam int CHANNEL_BITS = 8;
    localparam int PIX_BITS     = 3 * CHANNEL_BITS;
    localparam int SIDE_BITS    = $clog2(MAX_SIDE) + 1;
    localparam int IDX_BITS     = $clog2(MAX_SIDE);
    localparam int DEPTH        = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_BITS    = $clog2(DEPTH);
    localparam int CNT_BITS     = ADDR_BITS + 1;
    localparam int DIV_STEPS    = CNT_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    typedef logic [SIDE_BITS-1:0] t_side;
    typedef logic [IDX_BITS-1:0]  t_idx;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    localparam logic [1:0] REG_TURNS  = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic STATUS_VALID     = 1'b0;
    localparam logic STATUS_NOT_READY = 1'b1;

    localparam logic [1:0] TURNS_NONE  = 2'd0;
    localparam logic [1:0] TURNS_ONE   = 2'd1;
    localparam logic [1:0] TURNS_TWO   = 2'd2;
    localparam logic [1:0] TURNS_THREE = 2'd3;

    function automatic t_side clamp_side(input t_side v);
        t_side res;
        if (v == '0) begin
            res = t_side'(1);
        end else if (v > t_side'(MAX_SIDE)) begin
            res = t_side'(MAX_SIDE);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

[hw/rtl/square_image_quarter_rotator.sv]
// Top level of the square image quarter rotator: control, address generation and APB registers.
// Depends on sqrot_pkg and sqrot_ram.
//
// Requests arrive on the slave stream; tuser selects a load (0) or a fetch (1). A load
// writes one pixel of the image in raster order into the pixel memory and gives no
// result. A fetch gives one result on the master stream: the next pixel of the rotated
// square (or of the whole image with no turns), with tlast on the last pixel and tuser
// high when the image is not yet fully loaded. A not-ready answer is registered straight
// from the request; a pixel passes through ST_ADDR, where the address multiply feeds the
// registered memory read, and then ST_READ, which fills the output register; no new
// request is taken until the pixel is there. The first fetch after a register write
// first rebuilds the row and column counters with a 13-step serial divider. After a
// register write, requests are blocked while the image totals are recomputed.
// Reset clears the counters and restores the register defaults; the memory is not
// cleared. While the receiver stalls the result waits in the output register and no
// further request is taken.
module square_image_quarter_rotator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sqrot_pkg::PIX_BITS-1:0]       s_tdata,  // red_in, green_in, blue_in
    input  logic                                 s_tuser,  // operation
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [sqrot_pkg::PIX_BITS-1:0]       m_tdata,  // red_out, green_out, blue_out
    output logic                                 m_tlast,
    output logic                                 m_tuser,  // fetch_status
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sqrot_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [sqrot_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [sqrot_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                 pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADDR,
        ST_READ
    } t_state;

    t_state r_state;

    logic [1:0]       r_turns;
    sqrot_pkg::t_side r_width_reg;
    sqrot_pkg::t_side r_height_reg;

    logic             r_derive;
    logic             r_dirty;
    sqrot_pkg::t_side r_w;
    sqrot_pkg::t_side r_n;
    sqrot_pkg::t_cnt  r_in_total;
    sqrot_pkg::t_cnt  r_out_total;

    sqrot_pkg::t_cnt  r_loaded;
    sqrot_pkg::t_cnt  r_emitted;
    sqrot_pkg::t_idx  r_i;
    sqrot_pkg::t_idx  r_j;
    sqrot_pkg::t_cnt  r_k;
    logic             r_last;

    sqrot_pkg::t_cnt                 r_dq;
    sqrot_pkg::t_side                r_dr;
    logic [sqrot_pkg::STEP_BITS-1:0] r_step;

    logic                              r_m_valid;
    logic                              n_m_valid;
    logic [sqrot_pkg::PIX_BITS-1:0]    r_m_data;
    logic                              r_m_last;
    logic                              r_m_user;

    logic cfg_wr;
    logic accept;
    logic out_free;

    sqrot_pkg::t_side w_clamped;
    sqrot_pkg::t_side h_clamped;
    sqrot_pkg::t_side n_min;

    logic [sqrot_pkg::SIDE_BITS:0] div_t;
    logic                          div_ge;
    sqrot_pkg::t_side              div_rem;
    sqrot_pkg::t_cnt               div_quo;

    sqrot_pkg::t_idx               nm1;
    sqrot_pkg::t_idx               row;
    sqrot_pkg::t_idx               col;
    logic [sqrot_pkg::CNT_BITS-1:0] rot_addr;
    logic [sqrot_pkg::ADDR_BITS-1:0] rd_addr;

    logic                           load_ok;
    logic                           emit_last;
    logic [sqrot_pkg::PIX_BITS-1:0] ram_rdata;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign out_free = !r_m_valid || m_tready;
    assign s_tready = (r_state == ST_IDLE) && !r_derive && out_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tlast  = r_m_last;
    assign m_tuser  = r_m_user;

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            sqrot_pkg::REG_TURNS:  prdata = sqrot_pkg::CFG_DATA_BITS'(r_turns);
            sqrot_pkg::REG_WIDTH:  prdata = sqrot_pkg::CFG_DATA_BITS'(r_width_reg);
            sqrot_pkg::REG_HEIGHT: prdata = sqrot_pkg::CFG_DATA_BITS'(r_height_reg);
            default:               prdata = '0;
        endcase
    end

    assign w_clamped = sqrot_pkg::clamp_side(r_width_reg);
    assign h_clamped = sqrot_pkg::clamp_side(r_height_reg);
    assign n_min     = (w_clamped < h_clamped) ? w_clamped : h_clamped;

    assign load_ok   = r_loaded < r_in_total;
    assign emit_last = r_emitted >= (r_out_total - sqrot_pkg::t_cnt'(1));

    assign div_t   = {r_dr, r_dq[sqrot_pkg::CNT_BITS-1]};
    assign div_ge  = div_t >= {1'b0, r_n};
    assign div_rem = div_ge ? sqrot_pkg::t_side'(div_t - {1'b0, r_n})
                            : sqrot_pkg::t_side'(div_t);
    assign div_quo = {r_dq[sqrot_pkg::CNT_BITS-2:0], div_ge};

    assign nm1 = sqrot_pkg::t_idx'(r_n - sqrot_pkg::t_side'(1));

    always_comb begin
        row = r_j;
        col = sqrot_pkg::t_idx'(nm1 - r_i);
        case (r_turns)
            sqrot_pkg::TURNS_TWO: begin
                row = sqrot_pkg::t_idx'(nm1 - r_i);
                col = sqrot_pkg::t_idx'(nm1 - r_j);
            end
            sqrot_pkg::TURNS_THREE: begin
                row = sqrot_pkg::t_idx'(nm1 - r_j);
                col = r_i;
            end
            default: begin
                row = r_j;
                col = sqrot_pkg::t_idx'(nm1 - r_i);
            end
        endcase
    end

    assign rot_addr = sqrot_pkg::CNT_BITS'(row * r_w) + sqrot_pkg::CNT_BITS'(col);
    assign rd_addr  = (r_turns == sqrot_pkg::TURNS_NONE) ? r_k[sqrot_pkg::ADDR_BITS-1:0]
                                                         : rot_addr[sqrot_pkg::ADDR_BITS-1:0];

    always_comb begin
        n_m_valid = r_m_valid && !m_tready;
        if (r_state == ST_READ) begin
            n_m_valid = 1'b1;
        end else if (accept && (s_tuser == sqrot_pkg::OP_FETCH) && load_ok) begin
            n_m_valid = 1'b1;
        end
    end

    sqrot_ram #(
        .WIDTH (sqrot_pkg::PIX_BITS),
        .DEPTH (sqrot_pkg::DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && (s_tuser == sqrot_pkg::OP_LOAD) && load_ok),
        .i_wr_addr (r_loaded[sqrot_pkg::ADDR_BITS-1:0]),
        .i_wr_data (s_tdata),
        .i_rd_en   (r_state == ST_ADDR),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_turns      <= sqrot_pkg::TURNS_NONE;
            r_width_reg  <= sqrot_pkg::t_side'(sqrot_pkg::MAX_SIDE);
            r_height_reg <= sqrot_pkg::t_side'(sqrot_pkg::MAX_SIDE);
            r_derive     <= 1'b0;
            r_dirty      <= 1'b0;
            r_w          <= sqrot_pkg::t_side'(sqrot_pkg::MAX_SIDE);
            r_n          <= sqrot_pkg::t_side'(sqrot_pkg::MAX_SIDE);
            r_in_total   <= sqrot_pkg::t_cnt'(sqrot_pkg::DEPTH);
            r_out_total  <= sqrot_pkg::t_cnt'(sqrot_pkg::DEPTH);
            r_loaded     <= '0;
            r_emitted    <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    sqrot_pkg::REG_TURNS:  r_turns      <= pwdata[1:0];
                    sqrot_pkg::REG_WIDTH:  r_width_reg  <= pwdata[sqrot_pkg::SIDE_BITS-1:0];
                    sqrot_pkg::REG_HEIGHT: r_height_reg <= pwdata[sqrot_pkg::SIDE_BITS-1:0];
                    default: ;
                endcase
                if (paddr[3:2] inside {sqrot_pkg::REG_TURNS, sqrot_pkg::REG_WIDTH,
                                       sqrot_pkg::REG_HEIGHT}) begin
                    r_derive <= 1'b1;
                    r_dirty  <= 1'b1;
                end
            end else begin
                r_derive <= 1'b0;
            end

            if (r_derive) begin
                r_w         <= w_clamped;
                r_n         <= n_min;
                r_in_total  <= sqrot_pkg::t_cnt'(w_clamped * h_clamped);
                r_out_total <= (r_turns == sqrot_pkg::TURNS_NONE)
                               ? sqrot_pkg::t_cnt'(w_clamped * h_clamped)
                               : sqrot_pkg::t_cnt'(n_min * n_min);
            end

            r_m_valid <= n_m_valid;

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_tuser == sqrot_pkg::OP_LOAD) begin
                            if (load_ok) begin
                                r_loaded <= r_loaded + sqrot_pkg::t_cnt'(1);
                            end
                        end else if (load_ok) begin
                            r_m_data  <= '0;
                            r_m_last  <= 1'b0;
                            r_m_user  <= sqrot_pkg::STATUS_NOT_READY;
                        end else begin
                            r_k    <= emit_last ? (r_out_total - sqrot_pkg::t_cnt'(1))
                                                : r_emitted;
                            r_last <= emit_last;
                            if (r_dirty) begin
                                r_dq    <= emit_last ? (r_out_total - sqrot_pkg::t_cnt'(1))
                                                     : r_emitted;
                                r_dr    <= '0;
                                r_step  <= '0;
                                r_state <= ST_DIV;
                            end else begin
                                r_state <= ST_ADDR;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    r_dq   <= div_quo;
                    r_dr   <= div_rem;
                    r_step <= r_step + 1'b1;
                    if (r_step == sqrot_pkg::STEP_BITS'(sqrot_pkg::DIV_STEPS - 1)) begin
                        r_i     <= div_quo[sqrot_pkg::IDX_BITS-1:0];
                        r_j     <= div_rem[sqrot_pkg::IDX_BITS-1:0];
                        r_dirty <= 1'b0;
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_m_data  <= ram_rdata;
                    r_m_last  <= r_last;
                    r_m_user  <= sqrot_pkg::STATUS_VALID;
                    if (r_last) begin
                        r_loaded  <= '0;
                        r_emitted <= '0;
                        r_i       <= '0;
                        r_j       <= '0;
                    end else begin
                        r_emitted <= r_k + sqrot_pkg::t_cnt'(1);
                        if (r_j == nm1) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/sqrot_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; no package needed.
module sqrot_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
